/* design/assert_macros.svh */
// Assertion macros included by fabric_request_arbiter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* design/fra_pkg.sv */
package fra_pkg;

    localparam int unsigned REQ_W   = 2;
    localparam int unsigned TAG_W   = 16;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned LVL_W   = 7;
    localparam int unsigned GAP_W   = 20;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_POLICY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_GAP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STARVE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP_MARK  = 2'd3;

    localparam logic [1:0] POL_RR = 2'd0;
    localparam logic [1:0] POL_CAPPED = 2'd2;

    localparam logic CMD_ENQ = 1'b0;

    typedef enum logic [1:0] {
        ST_ENQUEUED = 2'd0,
        ST_GRANTED  = 2'd1,
        ST_NONE     = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_OUT
    } t_state;

    typedef logic [REQ_W-1:0] t_order [4];
    localparam t_order ORDER_LATENCY = '{2'd0, 2'd3, 2'd1, 2'd2};
    localparam t_order ORDER_CAPPED  = '{2'd0, 2'd3, 2'd2, 2'd1};

    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] arrival;
        logic [LVL_W-1:0]  depth;
    } t_entry;

    typedef struct packed {
        logic              cmd;
        logic [REQ_W-1:0]  requester;
        logic [TAG_W-1:0]  request_tag;
        logic [TIME_W-1:0] now;
    } t_in;

    typedef struct packed {
        t_status           status;
        logic [TAG_W-1:0]  grant_tag;
        logic [REQ_W-1:0]  grant_requester;
        logic [TIME_W-1:0] wait_time;
        logic              starved;
        logic [LVL_W-1:0]  arrival_depth;
        logic [LVL_W-1:0]  queue_level;
        logic [LVL_W-1:0]  high_water;
        logic [TIME_W-1:0] token_ready_time;
    } t_out;

endpackage

/* design/fra_cell.sv */
module fra_cell (
    input  logic            i_clk,
    input  logic            i_load,
    input  logic            i_shift,
    input  fra_pkg::t_entry i_new,
    input  fra_pkg::t_entry i_right,
    output fra_pkg::t_entry o_entry
);
    import fra_pkg::*;

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_right;
        end else if (i_load) begin
            r_entry <= i_new;
        end
    end

    assign o_entry = r_entry;
endmodule

/* design/fabric_request_arbiter.sv */
// Channel  | Direction | Handshake            | Payload
// request  | in        | i_valid / o_stall    | i_req   (fra_pkg::t_in)
// result   | out       | o_valid / i_stall    | o_res   (fra_pkg::t_out)
// config   | in        | i_cfg_we             | i_cfg_idx, i_cfg_data
// Each request passes through accept, then matching all cells in parallel
// and picking the requester, then the registered result.
// Removal shifts the granted cell and every cell above it down by one.
// Reset is synchronous and active low; queue contents are not cleared.
// A stalled result holds, and the next request waits until it is taken.
module fabric_request_arbiter #(
    parameter int unsigned QUEUE_DEPTH = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  fra_pkg::t_in  i_req,
    output logic          o_valid,
    input  logic          i_stall,
    output fra_pkg::t_out o_res,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_data
);
    import fra_pkg::*;
    `include "assert_macros.svh"

    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned POS_W = $clog2(QUEUE_DEPTH);

    t_state r_state, n_state;
    t_in    r_in;
    t_out   r_out, n_out;
    logic [CNT_W-1:0] r_count, n_count, r_peak, n_peak;
    logic [REQ_W-1:0] r_last, n_last;
    logic [TIME_W-1:0] r_token, n_token;
    logic [1:0]  r_policy;
    logic [GAP_W-1:0] r_gap;
    logic [TIME_W-1:0] r_thresh;
    logic [LVL_W-1:0] r_mark;

    t_entry w_entry [QUEUE_DEPTH];
    logic   w_shift [QUEUE_DEPTH];
    logic   w_load  [QUEUE_DEPTH];
    t_entry w_new;
    logic   w_push, w_pop;
    logic [POS_W-1:0] w_pos;

    // Per-requester oldest match.
    logic [3:0] w_found;
    logic [POS_W-1:0] w_fpos [4];
    logic [3:0] w_elig;

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            w_found[r] = 1'b0;
            w_fpos[r]  = '0;
            for (int p = QUEUE_DEPTH - 1; p >= 0; p--) begin
                if ((CNT_W'(p) < r_count) && (w_entry[p].req == REQ_W'(r))) begin
                    w_found[r] = 1'b1;
                    w_fpos[r]  = POS_W'(p);
                end
            end
            w_elig[r] = w_found[r] &&
                ((r != 1) || (r_gap == '0) || (r_in.now >= r_token));
        end
    end

    logic             w_hit;
    logic [REQ_W-1:0] w_who;
    always_comb begin
        logic [REQ_W-1:0] c;
        w_hit = 1'b0;
        w_who = '0;
        for (int i = 0; i < 4; i++) begin
            if (r_policy == POL_RR) begin
                c = r_last + REQ_W'(i + 1);
            end else if (r_policy == POL_CAPPED) begin
                c = ORDER_CAPPED[i];
            end else begin
                c = ORDER_LATENCY[i];
            end
            if (!w_hit && w_elig[c]) begin
                w_hit = 1'b1;
                w_who = c;
            end
        end
    end

    t_entry w_g;
    logic [TIME_W-1:0] w_start;
    logic [TIME_W:0]   w_tsum;
    always_comb begin
        w_g     = w_entry[w_fpos[w_who]];
        w_start = (r_in.now > w_g.arrival) ? r_in.now : w_g.arrival;
        w_tsum  = {1'b0, w_start} + (TIME_W + 1)'(r_gap);
    end

    always_comb begin
        n_state = r_state;
        n_out   = r_out;
        n_count = r_count;
        n_peak  = r_peak;
        n_last  = r_last;
        n_token = r_token;
        w_push  = 1'b0;
        w_pop   = 1'b0;
        w_pos   = w_fpos[w_who];
        w_new.req     = r_in.requester;
        w_new.tag     = r_in.request_tag;
        w_new.arrival = r_in.now;
        w_new.depth   = LVL_W'(r_count);
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_out = '0;
                if (r_in.cmd == CMD_ENQ) begin
                    if (r_count >= CNT_W'(QUEUE_DEPTH)) begin
                        n_out.status = ST_FULL;
                    end else begin
                        w_push  = 1'b1;
                        n_count = r_count + CNT_W'(1);
                        if (n_count > r_peak) begin
                            n_peak = n_count;
                        end
                        n_out.status = ST_ENQUEUED;
                    end
                end else if (w_hit) begin
                    w_pop   = 1'b1;
                    n_count = r_count - CNT_W'(1);
                    if (r_policy == POL_RR) begin
                        n_last = w_who;
                    end
                    if (r_gap != '0 && w_who == REQ_W'(1)) begin
                        n_token = w_tsum[TIME_W] ? '1 : w_tsum[TIME_W-1:0];
                    end
                    n_out.status          = ST_GRANTED;
                    n_out.grant_tag       = w_g.tag;
                    n_out.grant_requester = w_g.req;
                    n_out.wait_time       = w_start - w_g.arrival;
                    n_out.starved = (n_out.wait_time > r_thresh) || (w_g.depth >= r_mark);
                    n_out.arrival_depth   = w_g.depth;
                end else begin
                    n_out.status = ST_NONE;
                end
                n_out.queue_level      = LVL_W'(n_count);
                n_out.high_water       = LVL_W'(n_peak);
                n_out.token_ready_time = n_token;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    generate
        for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_row
            t_entry w_right;
            if (k == QUEUE_DEPTH - 1) begin : g_last
                assign w_right = w_entry[k];
            end else begin : g_mid
                assign w_right = w_entry[k+1];
            end
            assign w_shift[k] = w_pop && (POS_W'(k) >= w_pos);
            assign w_load[k]  = w_push && (CNT_W'(k) == r_count);
            fra_cell u_cell (
                .i_clk   (i_clk),
                .i_load  (w_load[k]),
                .i_shift (w_shift[k]),
                .i_new   (w_new),
                .i_right (w_right),
                .o_entry (w_entry[k])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_peak   <= '0;
            r_last   <= REQ_W'(3);
            r_token  <= '0;
            r_policy <= '0;
            r_gap    <= '0;
            r_thresh <= 32'd52000;
            r_mark   <= 7'd36;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_peak  <= n_peak;
            r_last  <= n_last;
            r_token <= n_token;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_POLICY:    r_policy <= i_cfg_data[1:0];
                    CFG_TOKEN_GAP: r_gap    <= i_cfg_data[GAP_W-1:0];
                    CFG_STARVE:    r_thresh <= i_cfg_data;
                    CFG_CAP_MARK:  r_mark   <= i_cfg_data[LVL_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_in <= i_req;
        end
        r_out <= n_out;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_res   = r_out;

    `ASSERT_IMPLY(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(QUEUE_DEPTH))
    `ASSERT_IMPLY(a_peak_ge_count, i_clk, i_rst_n, 1'b1, r_peak >= r_count)
    `ASSERT_IMPLY(a_push_pop_excl, i_clk, i_rst_n, w_push, !w_pop)
    `ASSERT_NEXT(a_scan_to_out, i_clk, i_rst_n, r_state == S_SCAN, o_valid)
endmodule
